### rtl/mkt_pkg.sv
package mkt_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MISS_KEY_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIT_RIGHT_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT     = 2'd2;

  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_WRITE     = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] packet_key;
    logic [31:0] packet_payload;
    logic        payload_present;
    logic [5:0]  write_index;
    logic [31:0] write_match_key;
    logic [31:0] write_match_mask;
    logic [31:0] write_base_atom;
  } in_t;

  typedef struct packed {
    logic [31:0] out_key;
    logic [31:0] out_payload;
    logic        out_payload_present;
    logic        table_hit;
  } out_t;

endpackage

### rtl/mkt_ram.sv
module mkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = mkt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                      clk,
  input  logic                                      en,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/masked_key_translator.sv
// Translates packet keys through a sorted table of key/mask/base-atom entries and
// accepts one transaction per cycle, table writes and translations mixed in any
// order. Each step of the binary search is its own pipeline stage with its own copy
// of the key/mask table, so a translation passes $clog2(TABLE_DEPTH+1) search
// stages, then a base-atom fetch stage, then the output register (default depth
// 64). A write transaction flows down the same stages and updates each copy as
// it passes, so every translation sees exactly the writes that went in before it;
// a write gives no result. A stall at the output stops the whole pipeline. The
// tables are not cleared; entries below entry_count must be written before a
// translation is sent.
module masked_key_translator #(
  parameter int TABLE_DEPTH = mkt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mkt_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mkt_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [mkt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int SW     = CW + 1;
  localparam int XW     = (CW > 7) ? CW : 7;
  localparam int LEVELS = CW;

  typedef struct packed {
    mkt_pkg::in_t  req;
    logic [CW-1:0] lo;
    logic [CW-1:0] hi;
    logic [AW-1:0] mid;
    logic          hit;
    logic [AW-1:0] slot;
  } stg_t;

  logic [31:0] miss_key_mask_r;
  logic [4:0]  hit_right_shift_r;
  logic [6:0]  entry_count_r;

  logic          adv;
  logic [CW-1:0] count_lim;
  stg_t          ent_stg [LEVELS+1];
  logic [LEVELS:0] ent_vld;
  stg_t          stg_r [LEVELS+1];
  logic [LEVELS:0] vld_r;
  logic [63:0]   srch_rdata [LEVELS];
  logic [63:0]   fin_rdata;

  logic          out_valid_r;
  mkt_pkg::out_t out_data_r;
  mkt_pkg::out_t out_nxt;
  logic [31:0]   hit_key;

  function automatic logic wr_ok(mkt_pkg::in_t r);
    return XW'(r.write_index) < XW'(TABLE_DEPTH);
  endfunction

  // One binary search step against the entry fetched for this stage.
  function automatic stg_t search_step(stg_t s, logic [63:0] d);
    stg_t        n;
    logic [31:0] ek;
    logic [31:0] em;
    n  = s;
    ek = d[31:0];
    em = d[63:32];
    if (!s.hit && (s.lo < s.hi)) begin
      if ((s.req.packet_key & em) == ek) begin
        n.hit  = 1'b1;
        n.slot = s.mid;
      end else if (ek < s.req.packet_key) begin
        n.lo = CW'(s.mid) + CW'(1);
      end else begin
        n.hi = CW'(s.mid);
      end
    end
    n.mid = AW'((SW'(n.lo) + SW'(n.hi)) >> 1);
    return n;
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      miss_key_mask_r   <= '1;
      hit_right_shift_r <= '0;
      entry_count_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mkt_pkg::CFG_MISS_KEY_MASK:   miss_key_mask_r   <= cfg_data;
        mkt_pkg::CFG_HIT_RIGHT_SHIFT: hit_right_shift_r <= cfg_data[4:0];
        mkt_pkg::CFG_ENTRY_COUNT:     entry_count_r     <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  assign count_lim = (XW'(entry_count_r) > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                              : CW'(entry_count_r);

  assign ent_stg[0] = '{req:  in_data,
                        lo:   '0,
                        hi:   count_lim,
                        mid:  AW'(count_lim >> 1),
                        hit:  1'b0,
                        slot: '0};
  assign ent_vld[0] = in_valid;

  // Each search level owns a copy of the key/mask table. The port reads for a
  // translation, or writes for a write transaction, at the edge the transaction
  // enters the level.
  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    logic lvl_write;

    assign lvl_write = (ent_stg[k].req.req_type == mkt_pkg::REQ_WRITE);

    mkt_ram #(
      .WIDTH (64),
      .DEPTH (TABLE_DEPTH)
    ) u_srch_ram (
      .clk   (clk),
      .en    (adv && ent_vld[k] && (!lvl_write || wr_ok(ent_stg[k].req))),
      .we    (lvl_write),
      .addr  (lvl_write ? AW'(ent_stg[k].req.write_index) : ent_stg[k].mid),
      .wdata ({ent_stg[k].req.write_match_mask, ent_stg[k].req.write_match_key}),
      .rdata (srch_rdata[k])
    );

    assign ent_stg[k+1] = search_step(stg_r[k], srch_rdata[k]);
    assign ent_vld[k+1] = vld_r[k];
  end

  // Mask and base atom of the hit slot.
  logic fin_write;

  assign fin_write = (ent_stg[LEVELS].req.req_type == mkt_pkg::REQ_WRITE);

  mkt_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_DEPTH)
  ) u_fin_ram (
    .clk   (clk),
    .en    (adv && ent_vld[LEVELS] && (!fin_write || wr_ok(ent_stg[LEVELS].req))),
    .we    (fin_write),
    .addr  (fin_write ? AW'(ent_stg[LEVELS].req.write_index) : ent_stg[LEVELS].slot),
    .wdata ({ent_stg[LEVELS].req.write_match_mask, ent_stg[LEVELS].req.write_base_atom}),
    .rdata (fin_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= ent_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= LEVELS; k++) begin
        stg_r[k] <= ent_stg[k];
      end
    end
  end

  assign hit_key = ((stg_r[LEVELS].req.packet_key & ~fin_rdata[63:32]) >> hit_right_shift_r)
                   + fin_rdata[31:0];

  always_comb begin
    out_nxt.out_key = stg_r[LEVELS].hit ? hit_key
                                        : (stg_r[LEVELS].req.packet_key & miss_key_mask_r);
    out_nxt.out_payload = stg_r[LEVELS].req.payload_present ?
                          stg_r[LEVELS].req.packet_payload : 32'd0;
    out_nxt.out_payload_present = stg_r[LEVELS].req.payload_present;
    out_nxt.table_hit           = stg_r[LEVELS].hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LEVELS] &&
                     (stg_r[LEVELS].req.req_type == mkt_pkg::REQ_TRANSLATE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A transaction that reaches the last stage without a hit has closed its range.
  a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LEVELS] && !stg_r[LEVELS].hit |-> stg_r[LEVELS].lo >= stg_r[LEVELS].hi)
    else $error("search range still open after the last level");

  // A hit slot always lies inside the remaining search range.
  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LEVELS] && stg_r[LEVELS].hit |-> CW'(stg_r[LEVELS].slot) < stg_r[LEVELS].hi)
    else $error("hit slot outside the search range");

  // A write transaction leaving the pipeline never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld_r[LEVELS] && (stg_r[LEVELS].req.req_type == mkt_pkg::REQ_WRITE)
    |=> !out_valid_r)
    else $error("table write produced a result");

endmodule
